@@ rtl/rrd_pkg.sv @@
// Shared types, codes and limits for the request deframer.
// No dependencies; used by rrd_step and rpc_request_deframer_top.
package rrd_pkg;

    // Line length that is cut off as overlong; accepted lines hold at most MAX_LINE - 1 bytes before LF.
    localparam int MAX_LINE = 4096;
    localparam int LINE_W   = $clog2(MAX_LINE + 1);
    localparam logic [LINE_W-1:0] LINE_LIMIT = LINE_W'(MAX_LINE);

    localparam logic [62:0] SEQ_MAX = {63{1'b1}};

    // Parser phases.
    localparam logic [2:0] PH_LINE    = 3'd0;
    localparam logic [2:0] PH_DISCARD = 3'd1;
    localparam logic [2:0] PH_HEADER  = 3'd2;
    localparam logic [2:0] PH_NAME    = 3'd3;
    localparam logic [2:0] PH_DATA    = 3'd4;

    // Event codes.
    localparam logic [2:0] EV_NONE    = 3'd0;
    localparam logic [2:0] EV_SERVICE = 3'd1;
    localparam logic [2:0] EV_METHOD  = 3'd2;
    localparam logic [2:0] EV_LINE_OK = 3'd3;
    localparam logic [2:0] EV_REJECT  = 3'd4;
    localparam logic [2:0] EV_HEADER  = 3'd5;
    localparam logic [2:0] EV_NAME    = 3'd6;
    localparam logic [2:0] EV_DATA    = 3'd7;

    // Error codes.
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_MALFORMED = 2'd1;
    localparam logic [1:0] ERR_TOO_LONG  = 2'd2;

    // Characters.
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [3:0] COUNT_SAT  = 4'd10;
    localparam logic [3:0] COUNT_MAX  = 4'd9;
    localparam logic [2:0] HDR_LAST   = 3'd7;

    typedef struct packed {
        logic [2:0]        phase;
        logic [1:0]        tok_pos;
        logic              tok_ne;
        logic [LINE_W-1:0] line_len;
        logic              line_bad;
        logic [3:0]        cnt_acc;
        logic [62:0]       seq_acc;
        logic              seq_done;
        logic              cr_pending;
        logic [3:0]        args_total;
        logic [3:0]        cur_arg;
        logic [55:0]       hdr_shift;
        logic [2:0]        hdr_cnt;
        logic [15:0]       name_rem;
        logic [31:0]       data_rem;
    } t_state;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [7:0]  data_byte;
        logic [3:0]  arg_index;
        logic [3:0]  arg_count;
        logic [62:0] sequence_res;
        logic [15:0] arg_kind;
        logic [15:0] type_name_length;
        logic [31:0] data_length;
        logic        arg_last;
        logic        request_done;
        logic [1:0]  error_code;
    } t_result;

endpackage

@@ rtl/rrd_step.sv @@
// Next-state and result logic for one received byte of the deframer.
// Depends on rrd_pkg for state and result types and all codes.
module rrd_step (
    input  rrd_pkg::t_state  i_state,
    input  logic [7:0]       i_byte,
    output rrd_pkg::t_state  o_state,
    output rrd_pkg::t_result o_result
);

    function automatic rrd_pkg::t_state f_clear_line(rrd_pkg::t_state s);
        rrd_pkg::t_state t;
        t            = s;
        t.tok_pos    = '0;
        t.tok_ne     = 1'b0;
        t.line_len   = '0;
        t.line_bad   = 1'b0;
        t.cnt_acc    = '0;
        t.seq_acc    = '0;
        t.seq_done   = 1'b0;
        t.cr_pending = 1'b0;
        return t;
    endfunction

    // Closes the current argument, moving to the next header or back to the line.
    function automatic rrd_pkg::t_state f_finish(rrd_pkg::t_state s, logic last);
        rrd_pkg::t_state t;
        t = s;
        if (last) begin
            t.phase      = rrd_pkg::PH_LINE;
            t.cur_arg    = '0;
            t.args_total = '0;
        end else begin
            t.cur_arg = s.cur_arg + 4'd1;
            t.phase   = rrd_pkg::PH_HEADER;
            t.hdr_cnt = '0;
        end
        return t;
    endfunction

    logic                      c_digit;
    logic [3:0]                c_dval;
    logic [6:0]                c_cnt_next;
    logic [66:0]               c_seq_next;
    logic                      c_seq_sat;
    logic                      c_last_arg;
    logic                      c_bad;
    logic [rrd_pkg::LINE_W-1:0] c_len_inc;
    logic [15:0]               c_name_dec;
    logic [31:0]               c_data_dec;
    logic [15:0]               c_hdr_name;
    logic [31:0]               c_hdr_data;

    always_comb begin
        c_digit    = (i_byte >= rrd_pkg::CH_ZERO) && (i_byte <= rrd_pkg::CH_NINE);
        c_dval     = i_byte[3:0];
        c_cnt_next = ({3'b0, i_state.cnt_acc} << 3) + ({3'b0, i_state.cnt_acc} << 1)
                   + {3'b0, c_dval};
        // Ten times the largest accumulator plus a digit needs 67 bits.
        c_seq_next = ({4'b0, i_state.seq_acc} << 3) + ({4'b0, i_state.seq_acc} << 1)
                   + {63'b0, c_dval};
        c_seq_sat  = c_seq_next > {4'b0, rrd_pkg::SEQ_MAX};
        c_last_arg = ({1'b0, i_state.cur_arg} + 5'd1) >= {1'b0, i_state.args_total};
        c_len_inc  = i_state.line_len + {{(rrd_pkg::LINE_W-1){1'b0}}, 1'b1};
        c_name_dec = (i_state.name_rem != '0) ? i_state.name_rem - 16'd1 : '0;
        c_data_dec = (i_state.data_rem != '0) ? i_state.data_rem - 32'd1 : '0;
        c_hdr_name = i_state.hdr_shift[31:16];
        c_hdr_data = {i_byte, i_state.hdr_shift[55:32]};
        c_bad      = i_state.line_bad;

        o_state  = i_state;
        o_result = '0;

        case (i_state.phase)
            rrd_pkg::PH_LINE: begin
                if (i_byte == rrd_pkg::CH_LF) begin
                    if (!i_state.line_bad && i_state.tok_pos == 2'd3 && i_state.tok_ne) begin
                        o_result.event_res    = rrd_pkg::EV_LINE_OK;
                        o_result.arg_count    = i_state.cnt_acc;
                        o_result.sequence_res = i_state.seq_acc;
                        o_state.args_total    = i_state.cnt_acc;
                        o_state.cur_arg       = '0;
                        if (i_state.cnt_acc == '0) begin
                            o_result.request_done = 1'b1;
                        end else begin
                            o_state.phase   = rrd_pkg::PH_HEADER;
                            o_state.hdr_cnt = '0;
                        end
                    end else begin
                        o_result.event_res  = rrd_pkg::EV_REJECT;
                        o_result.error_code = rrd_pkg::ERR_MALFORMED;
                    end
                    o_state = f_clear_line(o_state);
                end else if (c_len_inc >= rrd_pkg::LINE_LIMIT) begin
                    o_result.event_res  = rrd_pkg::EV_REJECT;
                    o_result.error_code = rrd_pkg::ERR_TOO_LONG;
                    o_state             = f_clear_line(o_state);
                    o_state.phase       = rrd_pkg::PH_DISCARD;
                end else begin
                    o_state.line_len = c_len_inc;
                    if (i_state.cr_pending) begin
                        c_bad              = 1'b1;
                        o_state.cr_pending = 1'b0;
                    end
                    if (i_byte == rrd_pkg::CH_SPACE) begin
                        if (i_state.tok_pos == 2'd3 || !i_state.tok_ne) begin
                            c_bad = 1'b1;
                        end else begin
                            o_state.tok_pos = i_state.tok_pos + 2'd1;
                            o_state.tok_ne  = 1'b0;
                        end
                    end else if (i_byte == rrd_pkg::CH_CR) begin
                        if (i_state.tok_pos == 2'd3 && i_state.tok_ne) begin
                            o_state.cr_pending = 1'b1;
                        end else begin
                            c_bad = 1'b1;
                        end
                    end else begin
                        case (i_state.tok_pos)
                            2'd0: begin
                                o_result.event_res = rrd_pkg::EV_SERVICE;
                                o_result.data_byte = i_byte;
                            end
                            2'd1: begin
                                o_result.event_res = rrd_pkg::EV_METHOD;
                                o_result.data_byte = i_byte;
                            end
                            2'd2: begin
                                if (c_digit) begin
                                    o_state.cnt_acc = (c_cnt_next > 7'd10) ? rrd_pkg::COUNT_SAT
                                                                          : c_cnt_next[3:0];
                                end else begin
                                    c_bad = 1'b1;
                                end
                            end
                            default: begin
                                if (!i_state.tok_ne && !c_digit) begin
                                    c_bad = 1'b1;
                                end
                                if (!i_state.seq_done) begin
                                    if (c_digit) begin
                                        o_state.seq_acc = c_seq_sat ? rrd_pkg::SEQ_MAX
                                                                    : c_seq_next[62:0];
                                    end else begin
                                        o_state.seq_done = 1'b1;
                                    end
                                end
                            end
                        endcase
                        o_state.tok_ne = 1'b1;
                        if (i_state.tok_pos == 2'd2 && o_state.cnt_acc > rrd_pkg::COUNT_MAX) begin
                            c_bad = 1'b1;
                        end
                    end
                    o_state.line_bad = c_bad;
                end
            end
            rrd_pkg::PH_DISCARD: begin
                if (i_byte == rrd_pkg::CH_LF) begin
                    o_state.phase = rrd_pkg::PH_LINE;
                end
            end
            rrd_pkg::PH_HEADER: begin
                if (i_state.hdr_cnt < rrd_pkg::HDR_LAST) begin
                    o_state.hdr_shift = {i_byte, i_state.hdr_shift[55:8]};
                    o_state.hdr_cnt   = i_state.hdr_cnt + 3'd1;
                end else begin
                    o_result.event_res        = rrd_pkg::EV_HEADER;
                    o_result.arg_index        = i_state.cur_arg;
                    o_result.arg_kind         = i_state.hdr_shift[15:0];
                    o_result.type_name_length = c_hdr_name;
                    o_result.data_length      = c_hdr_data;
                    o_state.name_rem          = c_hdr_name;
                    o_state.data_rem          = c_hdr_data;
                    o_state.hdr_cnt           = '0;
                    if (c_hdr_name != '0) begin
                        o_state.phase = rrd_pkg::PH_NAME;
                    end else if (c_hdr_data != '0) begin
                        o_state.phase = rrd_pkg::PH_DATA;
                    end else begin
                        o_result.arg_last     = 1'b1;
                        o_result.request_done = c_last_arg;
                        o_state               = f_finish(o_state, c_last_arg);
                    end
                end
            end
            rrd_pkg::PH_NAME: begin
                o_result.event_res = rrd_pkg::EV_NAME;
                o_result.data_byte = i_byte;
                o_result.arg_index = i_state.cur_arg;
                o_state.name_rem   = c_name_dec;
                if (c_name_dec == '0) begin
                    if (i_state.data_rem != '0) begin
                        o_state.phase = rrd_pkg::PH_DATA;
                    end else begin
                        o_result.arg_last     = 1'b1;
                        o_result.request_done = c_last_arg;
                        o_state               = f_finish(o_state, c_last_arg);
                    end
                end
            end
            default: begin
                o_result.event_res = rrd_pkg::EV_DATA;
                o_result.data_byte = i_byte;
                o_result.arg_index = i_state.cur_arg;
                o_state.data_rem   = c_data_dec;
                if (c_data_dec == '0) begin
                    o_result.arg_last     = 1'b1;
                    o_result.request_done = c_last_arg;
                    o_state               = f_finish(o_state, c_last_arg);
                end
            end
        endcase
    end

endmodule

@@ rtl/rpc_request_deframer_top.sv @@
// Top level of the request deframer: input register, parser state and result register.
// Depends on rrd_pkg and rrd_step.
//
// Channel | Direction | Handshake              | Payload
// --------+-----------+------------------------+---------------------------------------
// in      | sink      | i_in_valid / o_in_ready   | i_data_in (one byte of a request)
// out     | source    | o_out_valid / i_out_ready | o_event_res ... o_error_code
//
// Every accepted byte yields exactly one result; the byte waits in the input register and
// its result is then loaded into the result register, from which it is presented.
// A new byte may be taken in every cycle; with no output stall the sustained rate is one
// byte per cycle, set by the combinational parser update between input and result registers.
// A stalled output holds its result and back-pressure reaches the input in the same
// cycle, so a full pipeline still accepts a byte while its result is being taken.
// Reset (synchronous, active low) empties both registers and returns the parser to
// waiting for a request line; there is no clearing pass.
module rpc_request_deframer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_event_res,
    output logic [7:0]  o_data_byte,
    output logic [3:0]  o_arg_index,
    output logic [3:0]  o_arg_count,
    output logic [62:0] o_sequence_res,
    output logic [15:0] o_arg_kind,
    output logic [15:0] o_type_name_length,
    output logic [31:0] o_data_length,
    output logic        o_arg_last,
    output logic        o_request_done,
    output logic [1:0]  o_error_code
);

    // Input register: holds one received byte ahead of the parser.
    logic             r_in_valid;
    logic [7:0]       r_in_data;

    // Parser state, updated once per byte that moves into the result register.
    rrd_pkg::t_state  r_state;
    rrd_pkg::t_state  n_state;

    // Result register.
    logic             r_out_valid;
    rrd_pkg::t_result r_res;
    rrd_pkg::t_result n_res;

    logic             c_adv;
    logic             c_res_ready;

    // The result register can load when it is empty or its result is being taken.
    assign c_res_ready = !r_out_valid || i_out_ready;
    assign c_adv       = r_in_valid && c_res_ready;
    assign o_in_ready  = !r_in_valid || c_res_ready;

    rrd_step u_step (
        .i_state  (r_state),
        .i_byte   (r_in_data),
        .o_state  (n_state),
        .o_result (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_data <= i_data_in;
        end
    end

    // An all-zero state is the parser waiting for a request line.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else if (c_adv) begin
            r_state     <= n_state;
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_adv) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_event_res        = r_res.event_res;
    assign o_data_byte        = r_res.data_byte;
    assign o_arg_index        = r_res.arg_index;
    assign o_arg_count        = r_res.arg_count;
    assign o_sequence_res     = r_res.sequence_res;
    assign o_arg_kind         = r_res.arg_kind;
    assign o_type_name_length = r_res.type_name_length;
    assign o_data_length      = r_res.data_length;
    assign o_arg_last         = r_res.arg_last;
    assign o_request_done     = r_res.request_done;
    assign o_error_code       = r_res.error_code;

    // An error code appears exactly on rejects.
    a_err_on_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_error_code != rrd_pkg::ERR_NONE) ==
                         (o_event_res == rrd_pkg::EV_REJECT)))
        else $error("error code and reject event disagree");

    // Argument completion only comes with an argument event.
    a_last_on_arg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_arg_last) |->
            (o_event_res == rrd_pkg::EV_HEADER || o_event_res == rrd_pkg::EV_NAME ||
             o_event_res == rrd_pkg::EV_DATA))
        else $error("argument completion without argument event");

    // Within the argument phases the current index stays below the count.
    a_arg_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == rrd_pkg::PH_HEADER || r_state.phase == rrd_pkg::PH_NAME ||
         r_state.phase == rrd_pkg::PH_DATA) |-> (r_state.cur_arg < r_state.args_total))
        else $error("argument index beyond argument count");

    // Name phase always has bytes left to take.
    a_name_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == rrd_pkg::PH_NAME) |-> (r_state.name_rem != '0))
        else $error("name phase with nothing left");

    // A taken byte always lands in the input register.
    a_in_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_in_valid)
        else $error("accepted byte lost");

endmodule
